>>> rtl/psbs_pkg.sv
// ----------------------------------------------------------------------------
// psbs_pkg
// shared types, command and status codes, and sizes for the prefix sum
// bucket search block
// ----------------------------------------------------------------------------
package psbs_pkg;

  localparam int DEPTH       = 1024;
  localparam int ADDR_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS    = ADDR_BITS + 1;
  localparam int WEIGHT_BITS = 16;
  localparam int SUM_BITS    = 26;
  localparam int CMD_BITS    = 2;
  localparam int STAT_BITS   = 2;

  // item commands
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd2;

  // result status codes
  localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_ABOVE = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_BITS-1:0] STAT_EMPTY = 2'd3;

  typedef struct packed {
    logic [CMD_BITS-1:0]    cmd;
    logic [WEIGHT_BITS-1:0] weight;
    logic [SUM_BITS-1:0]    query_label;
  } in_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]  position;
    logic [STAT_BITS-1:0] status;
    logic [CNT_BITS-1:0]  entry_total;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the accepted beat
    logic exec;     // finish a non-search item in one step
    logic init;     // open the search window and issue the first probe
    logic step;     // consume one probe and issue the next
    logic publish;  // move the result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_search;    // latched item needs the table search
    logic search_done;  // this probe closes the search window
    logic out_busy;     // output register holds a beat that is stalled
  } dp_stat_t;

endpackage

>>> rtl/psbs_ctrl.sv
// ----------------------------------------------------------------------------
// psbs_ctrl
// sequencer for one item at a time: decide, search, hand off the result
// ----------------------------------------------------------------------------
module psbs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  psbs_pkg::dp_stat_t  stat,
  output psbs_pkg::ctrl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.is_search) begin
          cmd.init   = 1'b1;
          state_next = ST_SEARCH;
        end else begin
          cmd.exec   = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (stat.search_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/psbs_dpath.sv
// ----------------------------------------------------------------------------
// psbs_dpath
// prefix table memory, running total, search window and output register
// ----------------------------------------------------------------------------
module psbs_dpath (
  input  logic                clk,
  input  logic                rst,
  input  psbs_pkg::in_t       in_data,
  input  psbs_pkg::ctrl_cmd_t cmd,
  output psbs_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output psbs_pkg::out_t      out_data
);

  // prefix table, contents undefined until appended
  logic [psbs_pkg::SUM_BITS-1:0] mem [psbs_pkg::DEPTH];
  logic [psbs_pkg::SUM_BITS-1:0] rdata;
  logic [psbs_pkg::ADDR_BITS-1:0] rd_addr;
  logic                           we;

  logic [psbs_pkg::CNT_BITS-1:0]    entry_count;
  logic [psbs_pkg::SUM_BITS-1:0]    running_sum;
  logic [psbs_pkg::CMD_BITS-1:0]    item_cmd;
  logic [psbs_pkg::WEIGHT_BITS-1:0] item_weight;
  logic [psbs_pkg::SUM_BITS-1:0]    item_label;

  logic [psbs_pkg::CNT_BITS-1:0]  lo;
  logic [psbs_pkg::CNT_BITS-1:0]  hi;
  logic [psbs_pkg::ADDR_BITS-1:0] mid;

  logic [psbs_pkg::CNT_BITS-1:0]  res_position;
  logic [psbs_pkg::STAT_BITS-1:0] res_status;

  logic                           full;
  logic [psbs_pkg::SUM_BITS:0]    sum_wide;
  logic [psbs_pkg::SUM_BITS-1:0]  sum_sat;
  logic                           probe_ge;
  logic [psbs_pkg::CNT_BITS-1:0]  lo_next;
  logic [psbs_pkg::CNT_BITS-1:0]  hi_next;
  logic [psbs_pkg::CNT_BITS:0]    mid_sum;
  logic [psbs_pkg::ADDR_BITS-1:0] mid_next;

  assign full     = (entry_count == psbs_pkg::CNT_BITS'(psbs_pkg::DEPTH));
  assign sum_wide = {1'b0, running_sum} + (psbs_pkg::SUM_BITS + 1)'(item_weight);
  assign sum_sat  = sum_wide[psbs_pkg::SUM_BITS] ? '1 : sum_wide[psbs_pkg::SUM_BITS-1:0];

  // one probe: narrow the window on the registered table word
  assign probe_ge = (rdata >= item_label);
  assign lo_next  = probe_ge ? lo : (psbs_pkg::CNT_BITS'(mid) + 1'b1);
  assign hi_next  = probe_ge ? psbs_pkg::CNT_BITS'(mid) : hi;
  assign mid_sum  = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_next = mid_sum[psbs_pkg::ADDR_BITS:1];

  assign rd_addr = cmd.init ? entry_count[psbs_pkg::ADDR_BITS:1] : mid_next;
  assign we      = cmd.exec && (item_cmd == psbs_pkg::CMD_APPEND) && !full;

  assign stat.is_search   = (item_cmd == psbs_pkg::CMD_QUERY) &&
                            (entry_count != '0) && (item_label <= running_sum);
  assign stat.search_done = !(lo_next < hi_next);
  assign stat.out_busy    = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[entry_count[psbs_pkg::ADDR_BITS-1:0]] <= sum_sat;
    end
    rdata <= mem[rd_addr];
  end

  // item capture, search window and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd    <= in_data.cmd;
      item_weight <= in_data.weight;
      item_label  <= in_data.query_label;
    end
    if (cmd.init) begin
      lo  <= '0;
      hi  <= entry_count;
      mid <= entry_count[psbs_pkg::ADDR_BITS:1];
    end else if (cmd.step) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
      if (stat.search_done) begin
        res_position <= lo_next + 1'b1;
        res_status   <= psbs_pkg::STAT_OK;
      end
    end
    if (cmd.exec) begin
      res_position <= '0;
      unique case (item_cmd)
        psbs_pkg::CMD_APPEND: begin
          res_status <= full ? psbs_pkg::STAT_FULL : psbs_pkg::STAT_OK;
        end
        psbs_pkg::CMD_QUERY: begin
          res_status <= (entry_count == '0) ? psbs_pkg::STAT_EMPTY : psbs_pkg::STAT_ABOVE;
        end
        default: begin
          res_status <= psbs_pkg::STAT_OK;
        end
      endcase
    end
    if (cmd.publish) begin
      out_data.position    <= res_position;
      out_data.status      <= res_status;
      out_data.entry_total <= entry_count;
    end
  end

  // table bookkeeping and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.exec && (item_cmd == psbs_pkg::CMD_CLEAR)) begin
        entry_count <= '0;
        running_sum <= '0;
      end else if (we) begin
        entry_count <= entry_count + 1'b1;
        running_sum <= sum_sat;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/prefix_sum_bucket_search.sv
// ----------------------------------------------------------------------------
// prefix_sum_bucket_search
// cumulative weight table with lower-bound bucket lookup
// ----------------------------------------------------------------------------
// Each input beat is a clear, an append or a query, and each gives exactly one
// result beat. An append stores the saturated running total in the next table
// slot; a query binary-searches the table for the first slot whose total is
// at least the label and returns its 1-based position. Items are handled one
// at a time: clear, append and the error cases of a query go from acceptance
// through the decide and done states to the output register; a searching
// query adds a search state in between with one probe per step, at most
// ceil(log2(entries+1)) probes. The probe loop is set by the single read port
// of the table memory, whose registered word is compared and the next address
// issued in the same cycle. The next beat is taken as soon as the result sits
// in the output register, even while that beat is stalled downstream.
// ----------------------------------------------------------------------------
module prefix_sum_bucket_search (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  psbs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output psbs_pkg::out_t out_data
);

  // command and status between sequencer and datapath
  psbs_pkg::ctrl_cmd_t cmd;
  psbs_pkg::dp_stat_t  stat;

  // sequencer: idle, decide, search, hand off
  psbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table memory, running total, search window, output beat register
  psbs_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> bench/psbs_checker.sv
// ----------------------------------------------------------------------------
// psbs_checker
// watches both channels of the prefix sum bucket search block, keeps its own
// copy of the cumulative table and compares every result beat in order
// ----------------------------------------------------------------------------
module psbs_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  psbs_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  psbs_pkg::out_t out_data,
  output int             errors,
  output int             pending,
  output int             checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [psbs_pkg::SUM_BITS:0] SUM_MAX = {1'b0, {psbs_pkg::SUM_BITS{1'b1}}};

  // shadow state
  logic [psbs_pkg::SUM_BITS-1:0] cum_sums [psbs_pkg::DEPTH];
  logic [psbs_pkg::CNT_BITS-1:0] stored;
  logic [psbs_pkg::SUM_BITS-1:0] run_total;
  psbs_pkg::out_t                expected_results [$];

  // first slot whose cumulative sum reaches the label
  function automatic int find_bucket(input logic [psbs_pkg::SUM_BITS-1:0] label);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = int'(stored);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (cum_sums[mid[psbs_pkg::ADDR_BITS-1:0]] >= label) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  // apply one item to the shadow state and return the beat it must cause
  function automatic psbs_pkg::out_t predict_result(input psbs_pkg::in_t b);
    psbs_pkg::out_t              r;
    logic [psbs_pkg::SUM_BITS:0] s;
    r = '0;
    r.status = psbs_pkg::STAT_OK;
    case (b.cmd)
      psbs_pkg::CMD_CLEAR: begin
        stored    = '0;
        run_total = '0;
      end
      psbs_pkg::CMD_APPEND: begin
        if (stored >= psbs_pkg::DEPTH) begin
          r.status = psbs_pkg::STAT_FULL;
        end else begin
          s = {1'b0, run_total} + (psbs_pkg::SUM_BITS + 1)'(b.weight);
          if (s > SUM_MAX) s = SUM_MAX;
          run_total = s[psbs_pkg::SUM_BITS-1:0];
          cum_sums[stored[psbs_pkg::ADDR_BITS-1:0]] = run_total;
          stored    = stored + 1'b1;
        end
      end
      psbs_pkg::CMD_QUERY: begin
        if (stored == '0) begin
          r.status = psbs_pkg::STAT_EMPTY;
        end else if (b.query_label > run_total) begin
          r.status = psbs_pkg::STAT_ABOVE;
        end else begin
          r.position = psbs_pkg::CNT_BITS'(find_bucket(b.query_label) + 1);
        end
      end
      default: ;
    endcase
    r.entry_total = stored;
    return r;
  endfunction

  always @(posedge clk) begin
    psbs_pkg::out_t want;
    if (rst) begin
      stored    = '0;
      run_total = '0;
      expected_results.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no item waiting: position %0d status %0d entry_total %0d",
                 out_data.position, out_data.status, out_data.entry_total);
          errors++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (out_data.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_data.position);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.entry_total !== want.entry_total) begin
            $error("entry_total: expected %0d, got %0d", want.entry_total,
                   out_data.entry_total);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_result(in_data));
    end
    pending = expected_results.size();
  end

endmodule

>>> bench/tb_prefix_sum_bucket_search.sv
// ----------------------------------------------------------------------------
// tb_prefix_sum_bucket_search
// drives clear, append and query beats into the prefix sum bucket search
// block with bursty input and a patterned output stall; a checker beside the
// block predicts every result and the top gives the verdict
// ----------------------------------------------------------------------------
module tb_prefix_sum_bucket_search;
  timeunit 1ns;
  timeprecision 1ps;

  // spare command code, the block must treat it as a no-op
  localparam logic [psbs_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned LABEL_MAX    = (1 << psbs_pkg::SUM_BITS) - 1;
  localparam int unsigned WEIGHT_MAX   = (1 << psbs_pkg::WEIGHT_BITS) - 1;
  localparam int          TARGET_BEATS = 1425;
  localparam int          DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_COIN, STALL_HOLD, STALL_TOGGLE
  } stall_mode_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  psbs_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  psbs_pkg::out_t out_data;

  int errors;
  int pending;
  int checked;

  // stimulus side copy of the sums, only used to aim query labels
  int unsigned sums [$];
  int unsigned total = 0;

  int burst_left = 0;
  int n_beats    = 0;
  int n_clear    = 0;
  int n_append   = 0;
  int n_query    = 0;
  int n_unused   = 0;
  int n_full     = 0;

  prefix_sum_bucket_search uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  psbs_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  always #5 clk = ~clk;

  // receiver back-pressure: free run, coin flips, solid holds and toggling,
  // each for a random stretch, so stalls land on every phase of a search
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(4, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_COIN:   out_stall <= 1'($urandom_range(0, 1));
      STALL_HOLD:   out_stall <= 1'b1;
      STALL_TOGGLE: out_stall <= ~out_stall;
      default:      out_stall <= 1'b0;
    endcase
  end

  // present one beat from a falling edge, hold it until taken, then maybe
  // open a gap once the current burst is used up
  task automatic send_beat(input psbs_pkg::in_t b);
    int          gap;
    logic [63:0] noise;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_beats++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        // junk on the bus while valid is low, the block must ignore it
        noise    = {$urandom, $urandom};
        in_valid <= 1'b0;
        in_data  <= noise[$bits(psbs_pkg::in_t)-1:0];
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // build a beat, keep the label-aiming copy in step, and send it
  task automatic issue(input logic [psbs_pkg::CMD_BITS-1:0] cmd, input int unsigned w,
                       input int unsigned lbl);
    psbs_pkg::in_t b;
    b.cmd         = cmd;
    b.weight      = w[psbs_pkg::WEIGHT_BITS-1:0];
    b.query_label = lbl[psbs_pkg::SUM_BITS-1:0];
    case (cmd)
      psbs_pkg::CMD_CLEAR: begin
        sums.delete();
        total = 0;
        n_clear++;
      end
      psbs_pkg::CMD_APPEND: begin
        if (sums.size() < psbs_pkg::DEPTH) begin
          total += b.weight;
          sums.push_back(total);
        end else begin
          n_full++;
        end
        n_append++;
      end
      psbs_pkg::CMD_QUERY: n_query++;
      default:             n_unused++;
    endcase
    send_beat(b);
  endtask

  // zero weights are common on purpose: runs of equal sums test the lower bound
  function automatic int unsigned pick_weight();
    case ($urandom_range(0, 11))
      0, 1:    return 0;
      2:       return WEIGHT_MAX;
      3, 4:    return $urandom_range(1, 16);
      default: return $urandom_range(0, WEIGHT_MAX);
    endcase
  endfunction

  // labels mostly on or next to stored sums, some inside the range, some wild
  function automatic int unsigned pick_label();
    int unsigned pick;
    if (sums.size() == 0) return ($urandom_range(0, 1) != 0) ? 0 : ($urandom & LABEL_MAX);
    pick = sums[$urandom_range(0, sums.size() - 1)];
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return total;
      2:       return total + 1;
      3, 4:    return pick;
      5:       return pick + 1;
      6:       return (pick == 0) ? 0 : pick - 1;
      7, 8:    return $urandom_range(0, total);
      default: return $urandom & LABEL_MAX;
    endcase
  endfunction

  // short well-formed sets: mostly a clear, then appends and queries mixed,
  // with a sprinkle of unused commands and stray clears
  task automatic run_short_sets(input int until_beats);
    int len;
    int r;
    while (n_beats < until_beats) begin
      if ($urandom_range(0, 4) != 0) issue(psbs_pkg::CMD_CLEAR, $urandom, $urandom);
      len = $urandom_range(1, 24);
      repeat (len) begin
        r = $urandom_range(0, 19);
        if (r < 8) issue(psbs_pkg::CMD_APPEND, pick_weight(), $urandom);
        else if (r < 17) issue(psbs_pkg::CMD_QUERY, $urandom, pick_label());
        else if (r < 19) issue(CMD_UNUSED, $urandom, $urandom);
        else issue(psbs_pkg::CMD_CLEAR, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, unused command, ignored fields at all ones
    issue(psbs_pkg::CMD_QUERY, WEIGHT_MAX, 0);
    issue(psbs_pkg::CMD_QUERY, 0, LABEL_MAX);
    issue(CMD_UNUSED, WEIGHT_MAX, LABEL_MAX);
    issue(psbs_pkg::CMD_CLEAR, WEIGHT_MAX, LABEL_MAX);
    // zero-weight first bucket, label zero always lands on slot one
    issue(psbs_pkg::CMD_APPEND, 0, LABEL_MAX);
    issue(psbs_pkg::CMD_QUERY, 0, 0);
    issue(psbs_pkg::CMD_QUERY, 0, 1);
    // sums 0 0 max max max+1: the search has to skip the equal runs
    issue(psbs_pkg::CMD_APPEND, 0, 0);
    issue(psbs_pkg::CMD_APPEND, WEIGHT_MAX, 0);
    issue(psbs_pkg::CMD_APPEND, 0, 0);
    issue(psbs_pkg::CMD_APPEND, 1, 0);
    issue(psbs_pkg::CMD_QUERY, 0, 0);
    issue(psbs_pkg::CMD_QUERY, 0, 1);
    issue(psbs_pkg::CMD_QUERY, 0, WEIGHT_MAX);
    issue(psbs_pkg::CMD_QUERY, 0, WEIGHT_MAX + 1);
    issue(psbs_pkg::CMD_QUERY, 0, WEIGHT_MAX + 2);
    issue(psbs_pkg::CMD_QUERY, WEIGHT_MAX, LABEL_MAX);
    // unused command leaves the table alone
    issue(CMD_UNUSED, 0, 0);
    issue(psbs_pkg::CMD_QUERY, 0, WEIGHT_MAX + 1);
    // clear then query reports empty again
    issue(psbs_pkg::CMD_CLEAR, 0, 0);
    issue(psbs_pkg::CMD_QUERY, 0, 0);
    issue(psbs_pkg::CMD_APPEND, WEIGHT_MAX, 0);
    issue(psbs_pkg::CMD_QUERY, 0, WEIGHT_MAX);
    issue(psbs_pkg::CMD_QUERY, 0, 0);

    run_short_sets(200);

    // fill the table to capacity once, with the odd query on the way up
    issue(psbs_pkg::CMD_CLEAR, $urandom, $urandom);
    for (k = 0; k < psbs_pkg::DEPTH; k++) begin
      issue(psbs_pkg::CMD_APPEND, pick_weight(), $urandom);
      if ($urandom_range(0, 15) == 0) issue(psbs_pkg::CMD_QUERY, $urandom, pick_label());
    end
    // full table: appends bounce, queries run the deepest search
    repeat (24) begin
      if ($urandom_range(0, 3) == 0) issue(psbs_pkg::CMD_APPEND, pick_weight(), $urandom);
      else issue(psbs_pkg::CMD_QUERY, $urandom, pick_label());
    end
    issue(psbs_pkg::CMD_QUERY, $urandom, 0);
    issue(psbs_pkg::CMD_QUERY, $urandom, total);
    issue(psbs_pkg::CMD_APPEND, WEIGHT_MAX, $urandom);

    run_short_sets(TARGET_BEATS);

    // drain: nothing more to send, wait for every result, then a little more
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d beats: %0d clear, %0d append (%0d on a full table), %0d query, %0d unused",
             n_beats, n_clear, n_append, n_full, n_query, n_unused);
    $display("compared %0d result beats, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
